FILE: sv/imhq_pkg.sv
`timescale 1ns / 1ps
package imhq_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int ITEM_BITS  = 8;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 9;
    localparam int CAPACITY   = 256;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [ITEM_BITS-1:0] item_id;
        logic [KEY_BITS-1:0]  key;
        logic                 move_up;
    } req_t;

    typedef struct packed {
        logic                  top_valid;
        logic [ITEM_BITS-1:0]  top_item;
        logic [KEY_BITS-1:0]   top_key;
        logic [COUNT_BITS-1:0] entry_count;
        logic [1:0]            status;
    } rsp_t;

    // one heap slot
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [ITEM_BITS-1:0] item;
    } slot_t;

endpackage

FILE: sv/imhq_if.sv
`timescale 1ns / 1ps
interface imhq_req_if;
    logic             valid;
    logic             ready;
    imhq_pkg::req_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface imhq_rsp_if;
    logic             valid;
    logic             ready;
    imhq_pkg::rsp_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/imhq_slot_ram.sv
`timescale 1ns / 1ps
module imhq_slot_ram (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [imhq_pkg::SLOT_BITS-1:0] rd_addr,
    output imhq_pkg::slot_t               rd_data,
    input  logic                          wr_en,
    input  logic [imhq_pkg::SLOT_BITS-1:0] wr_addr,
    input  imhq_pkg::slot_t               wr_data
);
    import imhq_pkg::*;

    slot_t mem [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/imhq_pos_ram.sv
`timescale 1ns / 1ps
module imhq_pos_ram (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [imhq_pkg::ITEM_BITS-1:0] rd_addr,
    output logic [imhq_pkg::SLOT_BITS-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [imhq_pkg::ITEM_BITS-1:0] wr_addr,
    input  logic [imhq_pkg::SLOT_BITS-1:0] wr_data
);
    import imhq_pkg::*;

    logic [SLOT_BITS-1:0] mem [1 << ITEM_BITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/indexed_min_heap_queue_unit.sv
`timescale 1ns / 1ps
// Indexed binary min-heap of up to 256 (key, id) entries, smallest key on top, with an
// id-to-slot table so an id's key can be updated. One operation is worked at a time and
// each gives one response beat. The slot memory has one read and one write port with a
// registered read. A sift toward the root goes level by level: read parent, then
// compare and swap. A sift toward the leaves goes level by level: read left, read
// right, then decide and swap. Setup for an update is a table lookup and a check; for
// a pop it is a read of the last entry. The root is then read back and captured for
// the response. After the response beat is taken the block returns to idle, where it
// can accept the next request. The memories need no clearing pass after reset, since
// only entries inside the heap are ever used.
module indexed_min_heap_queue_unit (
    input  logic         clk,
    input  logic         rst_n,
    imhq_req_if.sink     req,
    imhq_rsp_if.source   rsp
);
    import imhq_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOOKUP = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_RDLAST = 4'd3;
    localparam logic [3:0] ST_LOAD   = 4'd4;
    localparam logic [3:0] ST_RDL    = 4'd6;
    localparam logic [3:0] ST_RDR    = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;
    localparam logic [3:0] ST_UPCMP  = 4'd9;
    localparam logic [3:0] ST_TOP    = 4'd10;
    localparam logic [3:0] ST_GOTTOP = 4'd11;
    localparam logic [3:0] ST_RESP   = 4'd12;

    logic [3:0]            state_reg;
    logic [COUNT_BITS-1:0] count_reg;
    req_t                  op_reg;
    logic [SLOT_BITS-1:0]  pos_reg;
    logic [SLOT_BITS-1:0]  oth_reg;
    slot_t                 cur_reg;
    slot_t                 lch_reg;
    logic [1:0]            status_reg;
    rsp_t                  rsp_reg;

    logic                  s_rd_en;
    logic [SLOT_BITS-1:0]  s_rd_addr;
    slot_t                 s_rd_data;
    logic                  s_wr_en;
    logic [SLOT_BITS-1:0]  s_wr_addr;
    slot_t                 s_wr_data;
    logic                  p_wr_en;
    logic [ITEM_BITS-1:0]  p_wr_addr;
    logic [SLOT_BITS-1:0]  p_wr_data;
    logic [SLOT_BITS-1:0]  p_rd_data;

    // second write of a swap is held in a register and done in the cycle after
    logic                  pend_reg;
    logic                  pend_pmap_reg;
    logic [SLOT_BITS-1:0]  pend_addr_reg;
    slot_t                 pend_data_reg;

    imhq_slot_ram u_slot (
        .clk     (clk),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data)
    );

    imhq_pos_ram u_pos (
        .clk     (clk),
        .rd_en   (1'b1),
        .rd_addr (req.payload.item_id),
        .rd_data (p_rd_data),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data)
    );

    logic [COUNT_BITS-1:0] lidx;
    logic [COUNT_BITS-1:0] ridx;
    logic [SLOT_BITS-1:0]  parent;
    assign lidx   = {pos_reg, 1'b1};
    assign ridx   = COUNT_BITS'({pos_reg, 1'b1}) + COUNT_BITS'(1);
    assign parent = SLOT_BITS'((pos_reg - SLOT_BITS'(1)) >> 1);

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_RESP);
    assign rsp.payload = rsp_reg;

    // sequencer: reads, compares and writes back one level at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= req.payload;
                        status_reg <= STATUS_OK;
                        state_reg  <= ST_TOP;
                        if (req.payload.func == FUNC_PUSH)
                        begin
                            if (count_reg >= COUNT_BITS'(CAPACITY))
                            begin
                                status_reg <= STATUS_FULL;
                            end
                            else
                            begin
                                pos_reg   <= SLOT_BITS'(count_reg);
                                cur_reg   <= '{key: req.payload.key,
                                               item: req.payload.item_id};
                                count_reg <= count_reg + COUNT_BITS'(1);
                                state_reg <= (count_reg == '0) ? ST_TOP : ST_UPCMP;
                            end
                        end
                        else if (req.payload.func == FUNC_POP)
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= STATUS_EMPTY;
                            end
                            else
                            begin
                                count_reg <= count_reg - COUNT_BITS'(1);
                                pos_reg   <= '0;
                                state_reg <= (count_reg == COUNT_BITS'(1)) ? ST_TOP
                                                                            : ST_RDLAST;
                            end
                        end
                        else if (req.payload.func == FUNC_UPDATE)
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= STATUS_EMPTY;
                            end
                            else
                            begin
                                state_reg <= ST_LOOKUP;
                            end
                        end
                    end
                end
                ST_LOOKUP:
                begin
                    pos_reg <= p_rd_data;
                    if (COUNT_BITS'(p_rd_data) < count_reg)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_CHECK:
                begin
                    if (s_rd_data.item == op_reg.item_id)
                    begin
                        cur_reg   <= '{key: op_reg.key, item: op_reg.item_id};
                        state_reg <= op_reg.move_up ? ST_UPCMP : ST_RDL;
                    end
                    else
                    begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_RDLAST:
                begin
                    cur_reg   <= s_rd_data;
                    state_reg <= ST_RDL;
                end
                ST_RDL:
                begin
                    // left child read issued here; the sink ends if there is no left child
                    state_reg <= (lidx < count_reg) ? ST_RDR : ST_TOP;
                end
                ST_RDR:
                begin
                    lch_reg   <= s_rd_data;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if ((ridx < count_reg) && (s_rd_data.key < lch_reg.key)
                        && (s_rd_data.key < cur_reg.key))
                    begin
                        oth_reg       <= SLOT_BITS'(ridx);
                        pend_reg      <= 1'b1;
                        pend_pmap_reg <= 1'b1;
                        pend_addr_reg <= SLOT_BITS'(ridx);
                        pend_data_reg <= cur_reg;
                        pos_reg       <= SLOT_BITS'(ridx);
                        state_reg     <= ST_RDL;
                    end
                    else if (lch_reg.key < cur_reg.key)
                    begin
                        oth_reg       <= SLOT_BITS'(lidx);
                        pend_reg      <= 1'b1;
                        pend_pmap_reg <= 1'b1;
                        pend_addr_reg <= SLOT_BITS'(lidx);
                        pend_data_reg <= cur_reg;
                        pos_reg       <= SLOT_BITS'(lidx);
                        state_reg     <= ST_RDL;
                    end
                    else
                    begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_UPCMP:
                begin
                    // parent read issued here; the rise ends at the root
                    if (pos_reg == '0)
                    begin
                        state_reg <= ST_TOP;
                    end
                    else
                    begin
                        state_reg <= ST_GOTTOP;
                        oth_reg   <= parent;
                    end
                end
                ST_GOTTOP:
                begin
                    if (s_rd_data.key > cur_reg.key)
                    begin
                        pend_reg      <= 1'b1;
                        // a shared id keeps the slot the parent moved into
                        pend_pmap_reg <= (s_rd_data.item != cur_reg.item);
                        pend_addr_reg <= oth_reg;
                        pend_data_reg <= cur_reg;
                        pos_reg       <= oth_reg;
                        state_reg     <= ST_UPCMP;
                    end
                    else
                    begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_TOP:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // response capture once the root read returns
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.entry_count <= count_reg;
            rsp_reg.top_valid   <= (count_reg != '0);
            rsp_reg.top_item    <= (count_reg != '0) ? s_rd_data.item : '0;
            rsp_reg.top_key     <= (count_reg != '0) ? s_rd_data.key : '0;
        end
    end

    // slot memory port usage per state
    always_comb
    begin
        s_rd_en   = 1'b1;
        s_rd_addr = '0;
        s_wr_en   = 1'b0;
        s_wr_addr = '0;
        s_wr_data = cur_reg;
        p_wr_en   = 1'b0;
        p_wr_addr = cur_reg.item;
        p_wr_data = pos_reg;
        if (pend_reg)
        begin
            // finish a swap: the moving entry lands in its new slot
            s_wr_en   = 1'b1;
            s_wr_addr = pend_addr_reg;
            s_wr_data = pend_data_reg;
            p_wr_en   = pend_pmap_reg;
            p_wr_addr = pend_data_reg.item;
            p_wr_data = pend_addr_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                s_rd_addr = SLOT_BITS'(count_reg - COUNT_BITS'(1));
                if (req.valid && req.payload.func == FUNC_PUSH
                    && count_reg < COUNT_BITS'(CAPACITY))
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = SLOT_BITS'(count_reg);
                    s_wr_data = '{key: req.payload.key, item: req.payload.item_id};
                    p_wr_en   = 1'b1;
                    p_wr_addr = req.payload.item_id;
                    p_wr_data = SLOT_BITS'(count_reg);
                end
            end
            ST_LOOKUP:
            begin
                s_rd_addr = p_rd_data;
            end
            ST_CHECK:
            begin
                if (s_rd_data.item == op_reg.item_id)
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = pos_reg;
                    s_wr_data = '{key: op_reg.key, item: op_reg.item_id};
                    if (op_reg.move_up)
                    begin
                        s_rd_addr = parent;
                    end
                end
            end
            ST_RDLAST:
            begin
                s_wr_en   = 1'b1;
                s_wr_addr = '0;
                s_wr_data = s_rd_data;
                p_wr_en   = 1'b1;
                p_wr_addr = s_rd_data.item;
                p_wr_data = '0;
            end
            ST_RDL:
            begin
                s_rd_addr = SLOT_BITS'(lidx);
            end
            ST_RDR:
            begin
                s_rd_addr = SLOT_BITS'(ridx);
            end
            ST_DECIDE:
            begin
                // child moves up into the current slot
                if ((ridx < count_reg) && (s_rd_data.key < lch_reg.key)
                    && (s_rd_data.key < cur_reg.key))
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = pos_reg;
                    s_wr_data = s_rd_data;
                    p_wr_en   = 1'b1;
                    p_wr_addr = s_rd_data.item;
                    p_wr_data = pos_reg;
                end
                else if (lch_reg.key < cur_reg.key)
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = pos_reg;
                    s_wr_data = lch_reg;
                    p_wr_en   = 1'b1;
                    p_wr_addr = lch_reg.item;
                    p_wr_data = pos_reg;
                end
            end
            ST_UPCMP:
            begin
                s_rd_addr = parent;
            end
            ST_GOTTOP:
            begin
                // parent moves down into the current slot
                if (s_rd_data.key > cur_reg.key)
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = pos_reg;
                    s_wr_data = s_rd_data;
                    p_wr_en   = 1'b1;
                    p_wr_addr = s_rd_data.item;
                    p_wr_data = pos_reg;
                end
            end
            ST_TOP:
            begin
                // root read for the response
                s_rd_addr = '0;
            end
            default:
            begin
                s_rd_addr = '0;
            end
        endcase
    end

endmodule

FILE: sv/imhq_checker.sv
`timescale 1ns / 1ps
module imhq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         req_valid,
    input logic         req_ready,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input imhq_pkg::rsp_t rsp_payload
);
    import imhq_pkg::*;

    // no new op accepted while a response waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while response pending");

    // response payload holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
        else $error("response changed while stalled");

    // count bounded by capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_payload.entry_count <= COUNT_BITS'(CAPACITY)))
        else $error("count beyond capacity");

    // top_valid matches count
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_payload.top_valid == (rsp_payload.entry_count != '0)))
        else $error("top valid disagrees with count");

endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
